[src/bukstk_pkg.sv]
// bukstk_pkg: shared types and constants for the bounded unique key stack
// no dependencies; imported by bukstk_mem, bukstk_ctrl and the top level

package bukstk_pkg;

    localparam int KEY_W     = 32;
    localparam int DATA_W    = 32;
    localparam int FILL_W    = 5;
    localparam int DEPTH_DEF = 16;

    typedef enum logic [1:0] {
        CMD_PUSH      = 2'd0,
        CMD_POP       = 2'd1,
        CMD_LIST_DOWN = 2'd2,
        CMD_LIST_UP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_DUP   = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        t_status                   status;
        logic                      entry_valid;
        logic signed [KEY_W-1:0]   key;
        logic signed [DATA_W-1:0]  data;
        logic                      last;
    } t_result;

endpackage

[src/bukstk_mem.sv]
// bukstk_mem: entry storage, one write port and one registered read port
// depends on bukstk_pkg for the key and data widths

module bukstk_mem #(
    parameter int DEPTH = bukstk_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [AW-1:0]                     i_wr_addr,
    input  logic signed [bukstk_pkg::KEY_W-1:0]  i_wr_key,
    input  logic signed [bukstk_pkg::DATA_W-1:0] i_wr_data,
    input  logic                              i_rd_en,
    input  logic [AW-1:0]                     i_rd_addr,
    output logic signed [bukstk_pkg::KEY_W-1:0]  o_rd_key,
    output logic signed [bukstk_pkg::DATA_W-1:0] o_rd_data
);
    import bukstk_pkg::*;

    logic [KEY_W+DATA_W-1:0] r_mem [DEPTH];
    logic [KEY_W+DATA_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_key, i_wr_data};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_key  = r_q[KEY_W+DATA_W-1:DATA_W];
    assign o_rd_data = r_q[DATA_W-1:0];

endmodule

[src/bukstk_ctrl.sv]
// bukstk_ctrl: command sequencer, fill count, duplicate scan and listing walk
// depends on bukstk_pkg; drives the ports of bukstk_mem

module bukstk_ctrl #(
    parameter int DEPTH = bukstk_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [1:0]                        i_cmd,
    input  logic signed [bukstk_pkg::KEY_W-1:0]  i_new_key,
    input  logic signed [bukstk_pkg::DATA_W-1:0] i_new_data,
    output logic                              o_busy,
    output logic                              o_wr_en,
    output logic [AW-1:0]                     o_wr_addr,
    output logic signed [bukstk_pkg::KEY_W-1:0]  o_wr_key,
    output logic signed [bukstk_pkg::DATA_W-1:0] o_wr_data,
    output logic                              o_rd_en,
    output logic [AW-1:0]                     o_rd_addr,
    input  logic signed [bukstk_pkg::KEY_W-1:0]  i_rd_key,
    input  logic signed [bukstk_pkg::DATA_W-1:0] i_rd_data,
    output logic                              o_strobe,
    output bukstk_pkg::t_result               o_result,
    output logic [CW-1:0]                     o_fill
);
    import bukstk_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_POP  = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    t_cmd                  r_cmd, n_cmd;
    logic signed [KEY_W-1:0]  r_key, n_key;
    logic signed [DATA_W-1:0] r_data, n_data;
    logic [CW-1:0]         r_issue, n_issue;
    logic                  r_rvld, n_rvld;
    logic                  r_rlast, n_rlast;
    logic                  r_dup, n_dup;
    logic                  r_strobe, n_strobe;
    t_result               r_res, n_res;
    logic [CW-1:0]         r_fill, n_fill;
    logic                  w_dup;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_data    = r_data;
        n_issue   = r_issue;
        n_dup     = r_dup;
        n_strobe  = 1'b0;
        n_res     = r_res;
        n_fill    = r_fill;
        o_wr_en   = 1'b0;
        o_wr_addr = AW'(r_count);
        o_wr_key  = r_key;
        o_wr_data = r_data;
        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        w_dup     = r_dup | (i_rd_key == r_key);

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_key   = i_new_key;
                    n_data  = i_new_data;
                    n_issue = '0;
                    n_dup   = 1'b0;
                    n_res   = '{status: ST_OK, entry_valid: 1'b0, key: '0, data: '0,
                                last: 1'b1};
                    n_fill  = r_count;
                    unique case (t_cmd'(i_cmd)) inside
                        CMD_PUSH: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_strobe     = 1'b1;
                                n_res.status = ST_FULL;
                            end else if (r_count == '0) begin
                                o_wr_en   = 1'b1;
                                o_wr_key  = i_new_key;
                                o_wr_data = i_new_data;
                                n_count   = CW'(1);
                                n_fill    = CW'(1);
                                n_strobe  = 1'b1;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        CMD_POP: begin
                            if (r_count == '0) begin
                                n_strobe     = 1'b1;
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_count   = r_count - CW'(1);
                                o_rd_en   = 1'b1;
                                o_rd_addr = AW'(r_count - CW'(1));
                                n_state   = S_POP;
                            end
                        end
                        CMD_LIST_DOWN, CMD_LIST_UP: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_issue != r_count) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = (r_cmd == CMD_LIST_DOWN) ? AW'(r_count - CW'(1) - r_issue)
                                                         : AW'(r_issue);
                    n_issue   = r_issue + CW'(1);
                end
                if (r_rvld) begin
                    if (r_cmd == CMD_PUSH) begin
                        n_dup = w_dup;
                        if (r_rlast) begin
                            n_state  = S_IDLE;
                            n_strobe = 1'b1;
                            n_res    = '{status: ST_OK, entry_valid: 1'b0, key: '0,
                                         data: '0, last: 1'b1};
                            if (w_dup) begin
                                n_res.status = ST_DUP;
                                n_fill       = r_count;
                            end else begin
                                o_wr_en = 1'b1;
                                n_count = r_count + CW'(1);
                                n_fill  = r_count + CW'(1);
                            end
                        end
                    end else begin
                        n_strobe = 1'b1;
                        n_res    = '{status: ST_OK, entry_valid: 1'b1, key: i_rd_key,
                                     data: i_rd_data, last: r_rlast};
                        n_fill   = r_count;
                        if (r_rlast) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_POP: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                n_res    = '{status: ST_OK, entry_valid: 1'b1, key: i_rd_key,
                             data: i_rd_data, last: 1'b1};
                n_fill   = r_count;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rvld  = (r_state == S_WALK) && o_rd_en;
        n_rlast = (r_state == S_WALK) && o_rd_en && ((r_issue + CW'(1)) == r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_issue  <= '0;
            r_rvld   <= 1'b0;
            r_rlast  <= 1'b0;
            r_dup    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_issue  <= n_issue;
            r_rvld   <= n_rvld;
            r_rlast  <= n_rlast;
            r_dup    <= n_dup;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_key  <= n_key;
        r_data <= n_data;
        r_res  <= n_res;
        r_fill <= n_fill;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;
    assign o_fill   = r_fill;

endmodule

[src/bounded_unique_key_stack.sv]
// bounded_unique_key_stack: LIFO stack of key/data pairs with duplicate key refusal
// depends on bukstk_pkg, bukstk_mem and bukstk_ctrl
//
//   channel   handshake          transfer
//   command   start, busy        start high while busy low
//   result    o_strobe           one cycle per result, no back pressure
//
// push: the duplicate scan reads every entry before the write; answers at once when empty or full
// pop: reads the top entry, then answers, at once when empty; list: one result per entry, at once when empty
// the rate is set by the single read port of the entry memory, one entry a cycle
// busy stays high until the final result of a command is on the result ports
// reset clears the entry count and the sequencer; o_fill_count, the result and entry contents are kept as is

module bounded_unique_key_stack #(
    parameter int DEPTH = bukstk_pkg::DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           i_cmd,
    input  logic signed [bukstk_pkg::KEY_W-1:0]  i_new_key,
    input  logic signed [bukstk_pkg::DATA_W-1:0] i_new_data,
    output logic                                 o_strobe,
    output logic [1:0]                           o_status,
    output logic                                 o_entry_valid,
    output logic signed [bukstk_pkg::KEY_W-1:0]  o_out_key,
    output logic signed [bukstk_pkg::DATA_W-1:0] o_out_data,
    output logic                                 o_last,
    output logic                                 o_is_empty,
    output logic [bukstk_pkg::FILL_W-1:0]        o_fill_count
);
    import bukstk_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                     w_wr_en;
    logic [AW-1:0]            w_wr_addr;
    logic signed [KEY_W-1:0]  w_wr_key;
    logic signed [DATA_W-1:0] w_wr_data;
    logic                     w_rd_en;
    logic [AW-1:0]            w_rd_addr;
    logic signed [KEY_W-1:0]  w_rd_key;
    logic signed [DATA_W-1:0] w_rd_data;
    t_result                  w_res;
    logic [CW-1:0]            w_fill;

    bukstk_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_key  (w_wr_key),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_key  (w_rd_key),
        .o_rd_data (w_rd_data)
    );

    bukstk_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cmd      (i_cmd),
        .i_new_key  (i_new_key),
        .i_new_data (i_new_data),
        .o_busy     (busy),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_key   (w_wr_key),
        .o_wr_data  (w_wr_data),
        .o_rd_en    (w_rd_en),
        .o_rd_addr  (w_rd_addr),
        .i_rd_key   (w_rd_key),
        .i_rd_data  (w_rd_data),
        .o_strobe   (o_strobe),
        .o_result   (w_res),
        .o_fill     (w_fill)
    );

    assign o_status      = w_res.status;
    assign o_entry_valid = w_res.entry_valid;
    assign o_out_key     = w_res.key;
    assign o_out_data    = w_res.data;
    assign o_last        = w_res.last;
    assign o_is_empty    = (w_fill == '0);
    assign o_fill_count  = FILL_W'(w_fill);

    // an accepted transaction either keeps the block busy or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_strobe)
        else $error("accepted transaction neither busy nor answered");

    // a non-final result means the walk is still running
    a_mid_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("non-final result while idle");

    // refused or empty answers are single results without an entry
    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != ST_OK) |-> o_last && !o_entry_valid)
        else $error("error status with entry or without last");

    // fill count never exceeds capacity
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (w_fill <= CW'(DEPTH)))
        else $error("fill count above capacity");

    // the write port and the read port are never enabled in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wr_en && w_rd_en))
        else $error("memory read and write in the same cycle");

endmodule
